@@ src/lflp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lflp_pkg
// Shared constants and codes for the linked free-list pool allocator.
// ----------------------------------------------------------------------------
package lflp_pkg;

    // Default number of pool entries.
    localparam int DEF_POOL_SIZE = 32;

    // Fixed field widths of the request and response beats.
    localparam int ENTRY_W  = 5;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

endpackage

@@ src/lflp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lflp_req_if / lflp_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface lflp_req_if
    import lflp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [ENTRY_W-1:0] entry_index;

    modport source (output valid, output operation, output entry_index, input ready);
    modport sink   (input valid, input operation, input entry_index, output ready);
endinterface

interface lflp_rsp_if
    import lflp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

@@ src/linked_free_list_pool_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_free_list_pool_core
// Fixed pool allocator keeping free and active entries in singly linked lists.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on req carries an operation (allocate or release) and, for
// a release, the entry index. Each request yields exactly one response beat
// on rsp with a status and the granted or released index.
// The link table lives in one synchronous memory (one read, one write port).
// Allocate: the free head's link is read and the head moves to the active list.
// Release: the active list is walked one link read per cycle from its head,
// so the response comes later the further down the list the entry sits; a
// miss walks the whole list, at most POOL_SIZE entries, before it reports.
// One request is worked on at a time; req.ready is high while the block is
// idle, also when a finished response still waits in the output register.
// If rsp stalls, the next finished response waits until the register frees.
// After reset the block chains the link memory in index order and holds
// req.ready low during that pass.
// ----------------------------------------------------------------------------
module linked_free_list_pool_core
    import lflp_pkg::*;
#(
    parameter int POOL_SIZE = DEF_POOL_SIZE
)(
    input  logic         clk,
    input  logic         rst_n,
    lflp_req_if.sink     req,
    lflp_rsp_if.source   rsp
);

    localparam int IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    localparam int CMP_W  = (LINK_W > ENTRY_W) ? LINK_W : ENTRY_W;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(POOL_SIZE - 1);

    // Sequencer states.
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_REL_RD = 3'd4;
    localparam logic [2:0] S_REL_WR = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    init_cnt_reg, init_cnt_next;
    logic [LINK_W-1:0]   free_head_reg, free_head_next;
    logic [LINK_W-1:0]   active_head_reg, active_head_next;
    logic [ENTRY_W-1:0]  want_reg, want_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [LINK_W-1:0]   after_reg, after_next;
    logic [LINK_W-1:0]   steps_reg, steps_next;
    logic                walk_first_reg, walk_first_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ENTRY_W-1:0]  res_index_reg, res_index_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ENTRY_W-1:0]  out_index_reg, out_index_next;

    // Link memory ports.
    logic [LINK_W-1:0] link_mem [POOL_SIZE];
    logic [LINK_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [LINK_W-1:0] mem_wd;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;

    logic [LINK_W-1:0] cur_w;
    logic              out_free;

    // Link memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[mem_ra];
        end
    end

    // During the walk the current entry is the head on the first step and the
    // link just read on every later step.
    assign cur_w    = walk_first_reg ? cur_reg : rd_data_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_index = out_index_reg;

    // Sequencer and list update logic.
    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        free_head_next   = free_head_reg;
        active_head_next = active_head_reg;
        want_next        = want_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        after_next       = after_reg;
        steps_next       = steps_reg;
        walk_first_next  = walk_first_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        mem_we           = 1'b0;
        mem_wa           = '0;
        mem_wd           = '0;
        mem_re           = 1'b0;
        mem_ra           = '0;

        case (state_reg)
            S_INIT:
            begin
                // Chain every entry to its successor; the last one gets the end marker.
                mem_we = 1'b1;
                mem_wa = init_cnt_reg;
                mem_wd = LINK_W'(init_cnt_reg) + LINK_W'(1);
                if (init_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        if (free_head_reg >= END_MARK)
                        begin
                            res_status_next = ST_EMPTY;
                            res_index_next  = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            // Fetch the link of the free head to find the new head.
                            mem_re     = 1'b1;
                            mem_ra     = free_head_reg[IDX_W-1:0];
                            state_next = S_ALLOC;
                        end
                    end
                    else
                    begin
                        want_next       = req.entry_index;
                        cur_next        = active_head_reg;
                        prev_next       = END_MARK;
                        steps_next      = '0;
                        walk_first_next = 1'b1;
                        state_next      = S_WALK;
                    end
                end
            end

            S_ALLOC:
            begin
                // Pop from the free list and push onto the active list.
                free_head_next   = rd_data_reg;
                mem_we           = 1'b1;
                mem_wa           = free_head_reg[IDX_W-1:0];
                mem_wd           = active_head_reg;
                active_head_next = free_head_reg;
                res_status_next  = ST_OK;
                res_index_next   = ENTRY_W'(free_head_reg);
                state_next       = S_EMIT;
            end

            S_WALK:
            begin
                if ((cur_w >= END_MARK) || (steps_reg == LINK_W'(POOL_SIZE)))
                begin
                    res_status_next = ST_NOT_ACTIVE;
                    res_index_next  = '0;
                    state_next      = S_EMIT;
                end
                else if (CMP_W'(cur_w) == CMP_W'(want_reg))
                begin
                    // Found: read its link to splice the list around it.
                    cur_next   = cur_w;
                    mem_re     = 1'b1;
                    mem_ra     = cur_w[IDX_W-1:0];
                    state_next = S_REL_RD;
                end
                else
                begin
                    prev_next       = cur_w;
                    mem_re          = 1'b1;
                    mem_ra          = cur_w[IDX_W-1:0];
                    steps_next      = steps_reg + LINK_W'(1);
                    walk_first_next = 1'b0;
                end
            end

            S_REL_RD:
            begin
                // Push the released entry onto the free list.
                after_next     = rd_data_reg;
                mem_we         = 1'b1;
                mem_wa         = cur_reg[IDX_W-1:0];
                mem_wd         = free_head_reg;
                free_head_next = cur_reg;
                state_next     = S_REL_WR;
            end

            S_REL_WR:
            begin
                // Close the gap in the active list.
                if (prev_reg == END_MARK)
                begin
                    active_head_next = after_reg;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = prev_reg[IDX_W-1:0];
                    mem_wd = after_reg;
                end
                res_status_next = ST_OK;
                res_index_next  = ENTRY_W'(cur_reg);
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_cnt_reg    <= '0;
            free_head_reg   <= '0;
            active_head_reg <= END_MARK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_cnt_reg    <= init_cnt_next;
            free_head_reg   <= free_head_next;
            active_head_reg <= active_head_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        want_reg       <= want_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        after_reg      <= after_next;
        steps_reg      <= steps_next;
        walk_first_reg <= walk_first_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

endmodule

@@ src/lflp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lflp_checker
// Port-level assertions for the pool allocator, bound to the allocator core.
// ----------------------------------------------------------------------------
module lflp_checker
    import lflp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [ENTRY_W-1:0]  rsp_granted_index
);

    logic [1:0] pending_reg;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    // Requests accepted whose response beat has not yet gone out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, req_beat} - {1'b0, rsp_beat};
        end
    end

    // A failed request reports index zero.
    a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_granted_index == '0))
        else $error("nonzero index on a failed response");

    // No response beat appears without a request behind it.
    a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("response without an outstanding request");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> !req_ready)
        else $error("request taken while previous one is in progress");

    // A stalled response holds its beat.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_granted_index)))
        else $error("response changed while stalled");

endmodule

bind linked_free_list_pool_core lflp_checker u_lflp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_granted_index (rsp.granted_index)
);

@@ bench/linked_free_list_pool_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_free_list_pool_core_tb
// Self-checking bench for the linked free-list pool allocator. A local copy
// of the free and active lists predicts the status and index of every
// response. Directed tests cover the empty pool, the empty active list, and
// releases at the head, middle and tail of the active list. Random traffic
// then sweeps the fill level between empty and full, with bursty requests
// and a stalling response side.
// ----------------------------------------------------------------------------
module linked_free_list_pool_core_tb;
    import lflp_pkg::*;

    localparam int POOL         = DEF_POOL_SIZE;
    localparam int END_MARK     = POOL;
    localparam int RANDOM_ITEMS = 560;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lflp_req_if req_ch ();
    lflp_rsp_if rsp_ch ();

    linked_free_list_pool_core #(.POOL_SIZE(POOL)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the pool: one link per entry plus the two list heads.
    logic [5:0] link_table [POOL];
    logic [5:0] active_head;
    logic [5:0] free_head;
    int         active_count;

    grant_t expected_grants[$];

    int error_count     = 0;
    int request_count   = 0;
    int response_count  = 0;
    int alloc_ok_count  = 0;
    int alloc_empty_cnt = 0;
    int release_ok_cnt  = 0;
    int release_miss    = 0;
    int cycle_count     = 0;
    int rsp_hold_cycles = 0;

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d responses still pending",
                     $realtime, cycle_count, expected_grants.size());
            $display("FAIL linked_free_list_pool_core");
            $finish;
        end
    end

    // Put the local pool into its reset state.
    function automatic void pool_reset();
        for (int i = 0; i < POOL; i++)
        begin
            link_table[i] = 6'(i + 1);
        end
        active_head  = 6'(END_MARK);
        free_head    = 6'd0;
        active_count = 0;
    endfunction

    // Apply one request to the local pool and work out its response.
    function automatic void pool_apply(input logic op, input logic [ENTRY_W-1:0] idx,
                                       output logic [STATUS_W-1:0] st,
                                       output logic [ENTRY_W-1:0] granted);
        logic [5:0] prev;
        logic [5:0] cur;
        int         steps;
        bit         found;
        st      = ST_OK;
        granted = '0;
        if (op == OP_ALLOC)
        begin
            cur = free_head;
            if (cur >= POOL)
            begin
                st = ST_EMPTY;
                alloc_empty_cnt++;
            end
            else
            begin
                free_head                = link_table[cur[4:0]];
                link_table[cur[4:0]]     = active_head;
                active_head              = cur;
                granted                  = cur[4:0];
                active_count++;
                alloc_ok_count++;
            end
        end
        else
        begin
            // Walk the active list from its head, at most one pass long.
            prev  = 6'(END_MARK);
            cur   = active_head;
            steps = 0;
            found = 1'b0;
            while (cur < POOL && steps < POOL && !found)
            begin
                if (cur == {1'b0, idx})
                    found = 1'b1;
                else
                begin
                    prev = cur;
                    cur  = link_table[cur[4:0]];
                    steps++;
                end
            end
            if (!found)
            begin
                st = ST_NOT_ACTIVE;
                release_miss++;
            end
            else
            begin
                if (prev == END_MARK)
                    active_head = link_table[cur[4:0]];
                else
                    link_table[prev[4:0]] = link_table[cur[4:0]];
                link_table[cur[4:0]] = free_head;
                free_head            = cur;
                granted              = cur[4:0];
                active_count--;
                release_ok_cnt++;
            end
        end
    endfunction

    // Entry at a given position on the active list, counted from the head.
    function automatic logic [ENTRY_W-1:0] active_entry_at(input int pos);
        logic [5:0] cur;
        cur = active_head;
        for (int i = 0; i < pos && cur < POOL; i++)
        begin
            cur = link_table[cur[4:0]];
        end
        return cur[4:0];
    endfunction

    // Offer one request beat and hold it until the block takes it.
    task automatic send_request(input logic op, input logic [ENTRY_W-1:0] idx);
        grant_t g;
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.entry_index <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pool_apply(op, idx, g.status, g.entry);
        expected_grants.push_back(g);
        request_count++;
    endtask

    // Leave the request side idle for a number of cycles.
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending until every predicted response has come back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_grants.size() > 0);
    endtask

    // Response side: stall pattern of its own, plus long hold-offs on request.
    initial
    begin : rsp_stall_pattern
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge clk);
                rsp_hold_cycles = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(4, 60);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each response beat with the oldest prediction.
    always @(posedge clk)
    begin : grant_checker
        grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                error_count++;
                $display("%0t: response with nothing expected, got status %0d index %0d",
                         $realtime, rsp_ch.status, rsp_ch.granted_index);
            end
            else
            begin
                want = expected_grants.pop_front();
                response_count++;
                if (rsp_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $realtime, want.status, rsp_ch.status);
                end
                if (rsp_ch.granted_index !== want.entry)
                begin
                    error_count++;
                    $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                             $realtime, want.entry, rsp_ch.granted_index);
                end
            end
        end
    end

    // Releases on an empty active list, at both index extremes.
    task automatic test_empty_pool_release();
        send_request(OP_RELEASE, 5'd0);
        send_request(OP_RELEASE, 5'd31);
        idle_cycles(2);
    endtask

    // Short allocate and release sequence hitting head, middle and tail.
    task automatic test_alloc_release_order();
        send_request(OP_ALLOC, 5'd31);
        send_request(OP_ALLOC, 5'd0);
        send_request(OP_ALLOC, 5'd17);
        // Active list is now 2 -> 1 -> 0.
        send_request(OP_RELEASE, 5'd1);
        send_request(OP_RELEASE, 5'd1);
        idle_cycles(3);
        send_request(OP_RELEASE, 5'd0);
        send_request(OP_RELEASE, 5'd2);
        send_request(OP_RELEASE, 5'd31);
        send_request(OP_ALLOC, 5'd0);
        send_request(OP_RELEASE, 5'd2);
        wait_for_results();
    endtask

    // Drain the free list, allocate past empty, then release everything back.
    task automatic test_exhaust_pool();
        int pos;
        while (free_head != END_MARK)
        begin
            send_request(OP_ALLOC, 5'($urandom_range(0, 31)));
            idle_cycles($urandom_range(0, 2));
        end
        send_request(OP_ALLOC, 5'd0);
        send_request(OP_ALLOC, 5'd31);
        send_request(OP_RELEASE, 5'd31);
        send_request(OP_RELEASE, 5'd0);
        send_request(OP_RELEASE, 5'd31);
        while (active_count > 0)
        begin
            case (active_count % 3)
                0:       pos = 0;
                1:       pos = active_count - 1;
                default: pos = $urandom_range(0, active_count - 1);
            endcase
            send_request(OP_RELEASE, active_entry_at(pos));
            idle_cycles($urandom_range(0, 2));
        end
        send_request(OP_RELEASE, 5'd16);
        wait_for_results();
    endtask

    // Response side holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        rsp_hold_cycles = 250;
        for (int i = 0; i < 8; i++)
        begin
            send_request(OP_ALLOC, 5'($urandom_range(0, 31)));
        end
        for (int i = 0; i < 4; i++)
        begin
            send_request(OP_RELEASE, active_entry_at($urandom_range(0, active_count - 1)));
        end
        wait_for_results();
    endtask

    // Random traffic that drifts the fill level between empty and full.
    task automatic test_random_traffic();
        int burst_left;
        int target_fill;
        int alloc_pct;
        logic [ENTRY_W-1:0] idx;
        burst_left  = 0;
        target_fill = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       target_fill = 0;
                    1:       target_fill = POOL;
                    default: target_fill = $urandom_range(0, POOL);
                endcase
            end
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            alloc_pct = (active_count < target_fill) ? 75 : 25;
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(OP_ALLOC, 5'($urandom_range(0, 31)));
            else
            begin
                if (active_count > 0 && $urandom_range(0, 99) < 85)
                    idx = active_entry_at($urandom_range(0, active_count - 1));
                else
                    idx = 5'($urandom_range(0, 31));
                send_request(OP_RELEASE, idx);
            end
            if (n % 160 == 159)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // Reset, the tests in turn, then the verdict.
    initial
    begin : test_sequence
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_ALLOC;
        req_ch.entry_index <= '0;
        pool_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_pool_release();
        test_alloc_release_order();
        test_exhaust_pool();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (POOL + 8) @(posedge clk);

        $display("Checked %0d responses to %0d requests.", response_count, request_count);
        $display("Grants %0d, pool empty %0d, releases %0d, not active %0d.",
                 alloc_ok_count, alloc_empty_cnt, release_ok_cnt, release_miss);
        if (error_count == 0 && expected_grants.size() == 0)
            $display("PASS linked_free_list_pool_core");
        else
            $display("FAIL linked_free_list_pool_core");
        $finish;
    end

endmodule
